[rtl/bcs_pkg.sv]
`timescale 1ns / 1ps

package bcs_pkg;

   localparam int ADC_BITS_DEFAULT = 10;

   localparam int SAMPLE_W  = 10;
   localparam int LEVEL_W   = 16;
   localparam int GAIN_W    = 16;
   localparam int INTERVAL_W = 10;
   localparam int ELAPSED_W = 17;
   localparam int GAIN_SHIFT = 10;

   localparam logic [ELAPSED_W-1:0] ELAPSED_MAX = '1;
   localparam logic [ELAPSED_W-1:0] MS_PER_UNIT = 17'd100;
   localparam logic [LEVEL_W-1:0]   LOW_SET_MARGIN   = 16'd15;
   localparam logic [LEVEL_W-1:0]   LOW_CLEAR_MARGIN = 16'd5;

   localparam logic [LEVEL_W-1:0]    START_LEVEL_RESET   = 16'd0;
   localparam logic [LEVEL_W-1:0]    STOP_LEVEL_RESET    = 16'd65535;
   localparam logic [INTERVAL_W-1:0] READ_INTERVAL_RESET = 10'd250;
   localparam logic [GAIN_W-1:0]     VOLT_GAIN_RESET     = 16'd400;

   typedef enum logic [1:0] {
      FUNC_TICK     = 2'd0,
      FUNC_AC_GAIN  = 2'd1,
      FUNC_AC_LOSS  = 2'd2,
      FUNC_RESET    = 2'd3
   } func_type;

   typedef enum logic [1:0] {
      REG_START_LEVEL   = 2'd0,
      REG_STOP_LEVEL    = 2'd1,
      REG_READ_INTERVAL = 2'd2,
      REG_VOLT_GAIN     = 2'd3
   } reg_index_type;

   // configuration with thresholds worked out at write time
   typedef struct packed {
      logic [LEVEL_W-1:0]   start_level;
      logic [LEVEL_W-1:0]   stop_level;
      logic [LEVEL_W-1:0]   low_set_level;
      logic [LEVEL_W-1:0]   low_clear_level;
      logic [ELAPSED_W-1:0] due_ms;
      logic [GAIN_W-1:0]    volt_gain;
   } cfg_type;

   typedef struct packed {
      logic                 charging;
      logic                 start_pending;
      logic                 low_flag;
      logic                 low_reported;
      logic                 reset_pending;
      logic [ELAPSED_W-1:0] elapsed_ms;
      logic [LEVEL_W-1:0]   last_level;
   } state_type;

   typedef struct packed {
      func_type            func;
      logic [SAMPLE_W-1:0] adc_sample;
      logic                ac_present;
      logic                in_call;
      logic                report_accepted;
   } item_type;

   typedef struct packed {
      logic               charge_on;
      logic               low_battery;
      logic               report_request;
      logic               reading_taken;
      logic [LEVEL_W-1:0] battery_level;
   } result_type;

endpackage

[rtl/bcs_csr.sv]
`timescale 1ns / 1ps

module bcs_csr (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          csr_valid,
   input  logic [1:0]                    csr_index,
   input  logic [15:0]                   csr_data,
   output bcs_pkg::cfg_type              cfg
);

   bcs_pkg::cfg_type cfg_ff;
   bcs_pkg::cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         case (bcs_pkg::reg_index_type'(csr_index))
            bcs_pkg::REG_START_LEVEL: begin
               cfg_in.start_level = csr_data;
               cfg_in.low_set_level = (csr_data > bcs_pkg::LOW_SET_MARGIN) ?
                  csr_data - bcs_pkg::LOW_SET_MARGIN : '0;
               cfg_in.low_clear_level = (csr_data > bcs_pkg::LOW_CLEAR_MARGIN) ?
                  csr_data - bcs_pkg::LOW_CLEAR_MARGIN : '0;
            end
            bcs_pkg::REG_STOP_LEVEL: cfg_in.stop_level = csr_data;
            bcs_pkg::REG_READ_INTERVAL:
               cfg_in.due_ms = bcs_pkg::ELAPSED_W'(csr_data[bcs_pkg::INTERVAL_W-1:0])
                               * bcs_pkg::MS_PER_UNIT;
            bcs_pkg::REG_VOLT_GAIN: cfg_in.volt_gain = csr_data;
            default: cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.start_level     <= bcs_pkg::START_LEVEL_RESET;
         cfg_ff.stop_level      <= bcs_pkg::STOP_LEVEL_RESET;
         cfg_ff.low_set_level   <= '0;
         cfg_ff.low_clear_level <= '0;
         cfg_ff.due_ms          <= bcs_pkg::ELAPSED_W'(bcs_pkg::READ_INTERVAL_RESET)
                                   * bcs_pkg::MS_PER_UNIT;
         cfg_ff.volt_gain       <= bcs_pkg::VOLT_GAIN_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

[rtl/bcs_step.sv]
`timescale 1ns / 1ps

module bcs_step #(
   parameter int ADC_BITS = bcs_pkg::ADC_BITS_DEFAULT
) (
   input  bcs_pkg::cfg_type    cfg,
   input  bcs_pkg::state_type  state,
   input  bcs_pkg::item_type   item,
   output bcs_pkg::state_type  state_next,
   output bcs_pkg::result_type result
);

   localparam logic [bcs_pkg::SAMPLE_W-1:0] SAMPLE_MASK =
      bcs_pkg::SAMPLE_W'((64'd1 << ADC_BITS) - 64'd1);
   localparam int PROD_W = bcs_pkg::SAMPLE_W + bcs_pkg::GAIN_W;

   logic [bcs_pkg::SAMPLE_W-1:0]  sample;
   logic [PROD_W-1:0]             product;
   logic [bcs_pkg::LEVEL_W-1:0]   level;
   logic [bcs_pkg::ELAPSED_W-1:0] elapsed_inc;
   logic                          due;

   assign sample  = item.adc_sample & SAMPLE_MASK;
   assign product = PROD_W'(sample) * PROD_W'(cfg.volt_gain);
   // 10-bit sample times 16-bit gain over 1024 always fits 16 bits
   assign level   = product[PROD_W-1:bcs_pkg::GAIN_SHIFT];
   assign elapsed_inc = (state.elapsed_ms == bcs_pkg::ELAPSED_MAX) ?
                        state.elapsed_ms : state.elapsed_ms + 1'b1;
   assign due = !item.in_call && (elapsed_inc >= cfg.due_ms);

   always_comb begin
      bcs_pkg::state_type s;
      logic report;
      logic taken;
      s      = state;
      report = 1'b0;
      taken  = 1'b0;
      case (item.func)
         bcs_pkg::FUNC_TICK: begin
            s.elapsed_ms = elapsed_inc;
            if (s.low_flag && !s.low_reported) begin
               report         = 1'b1;
               s.low_reported = item.report_accepted;
            end
            if (due) begin
               s.elapsed_ms = '0;
               s.last_level = level;
               taken        = 1'b1;
               if (s.reset_pending) begin
                  s.charging      = 1'b0;
                  s.start_pending = 1'b0;
                  s.low_flag      = 1'b0;
                  s.low_reported  = 1'b0;
                  s.reset_pending = 1'b0;
               end
               if (!s.charging) begin
                  if (level <= cfg.start_level) begin
                     s.start_pending = 1'b1;
                     s.charging      = item.ac_present;
                     if (!item.ac_present) begin
                        // low flag hysteresis below the start level
                        if (!s.low_flag && level <= cfg.low_set_level) begin
                           s.low_flag     = 1'b1;
                           s.low_reported = 1'b0;
                        end else if (s.low_flag && level >= cfg.low_clear_level) begin
                           s.low_flag     = 1'b0;
                           s.low_reported = 1'b0;
                        end
                     end
                  end
               end else begin
                  s.low_flag     = 1'b0;
                  s.low_reported = 1'b0;
                  if (level >= cfg.stop_level) begin
                     s.charging      = 1'b0;
                     s.start_pending = 1'b0;
                  end
               end
            end
         end
         bcs_pkg::FUNC_AC_GAIN: begin
            if (s.start_pending && !s.charging) begin
               s.charging = item.ac_present;
            end
         end
         bcs_pkg::FUNC_AC_LOSS: begin
            if (s.charging) begin
               s.charging      = 1'b0;
               s.start_pending = 1'b1;
            end
         end
         bcs_pkg::FUNC_RESET: s.reset_pending = 1'b1;
         default: s = state;
      endcase
      state_next            = s;
      result.charge_on      = s.charging;
      result.low_battery    = s.low_flag;
      result.report_request = report;
      result.reading_taken  = taken;
      result.battery_level  = s.last_level;
   end

endmodule

[rtl/battery_charge_supervisor.sv]
`timescale 1ns / 1ps

// battery charge supervisor
// req channel: one word per request; tuser carries the request kind (tick, ac gained,
//   ac lost, reset request), tdata the converter sample and the ac, call and
//   report-accepted flags
// rsp channel: exactly one word per request, in request order, with the charger drive,
//   low battery flag, report and reading strobes and the last level in centivolts
// csr channel: register writes (start level, stop level, read interval, gain), always
//   ready; write only while no request is in flight
// path: input register, then one pass of the step logic into the response register
// throughput: one request per cycle while the response side is not stalled; the
//   supervisor state is updated in the same pass that loads the response register,
//   so the next request sees it at once
// when rsp_tready is low the response holds and the input register still takes one
//   more word; req_tready drops only when both registers are full
// reset clears the state, the registers to their defaults and both channels
module battery_charge_supervisor #(
   parameter int ADC_BITS = bcs_pkg::ADC_BITS_DEFAULT
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   // [9:0] adc_sample, [10] ac_present, [11] in_call, [12] report_accepted
   input  logic [15:0] req_tdata,
   // [1:0] func
   input  logic [1:0]  req_tuser,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // [0] charge_on, [1] low_battery, [2] report_request, [3] reading_taken,
   // [19:4] battery_level
   output logic [23:0] rsp_tdata,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [1:0]  csr_index,
   input  logic [15:0] csr_data
);

   bcs_pkg::cfg_type    cfg;
   bcs_pkg::state_type  state_ff, state_in;
   bcs_pkg::item_type   item_ff, item_in;
   bcs_pkg::result_type result_ff, result_in;
   logic                item_valid_ff;
   logic                rsp_valid_ff;
   logic                step_fire;

   assign csr_ready = 1'b1;

   bcs_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .cfg       (cfg)
   );

   bcs_step #(
      .ADC_BITS (ADC_BITS)
   ) u_step (
      .cfg        (cfg),
      .state      (state_ff),
      .item       (item_ff),
      .state_next (state_in),
      .result     (result_in)
   );

   assign step_fire  = item_valid_ff && (!rsp_valid_ff || rsp_tready);
   assign req_tready = !item_valid_ff || step_fire;

   always_comb begin
      item_in.func            = bcs_pkg::func_type'(req_tuser);
      item_in.adc_sample      = req_tdata[9:0];
      item_in.ac_present      = req_tdata[10];
      item_in.in_call         = req_tdata[11];
      item_in.report_accepted = req_tdata[12];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         item_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
         state_ff      <= '0;
      end else begin
         if (req_tready) begin
            item_valid_ff <= req_tvalid;
         end
         if (step_fire) begin
            rsp_valid_ff <= 1'b1;
            state_ff     <= state_in;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_tready && req_tvalid) begin
         item_ff <= item_in;
      end
      if (step_fire) begin
         result_ff <= result_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {4'b0, result_ff.battery_level, result_ff.reading_taken,
                        result_ff.report_request, result_ff.low_battery,
                        result_ff.charge_on};

   // losing ac always drops the charger
   assert property (@(posedge clock) disable iff (reset)
      step_fire && item_ff.func == bcs_pkg::FUNC_AC_LOSS |=> !state_ff.charging)
      else $error("charger still on after ac loss");

   // a reading restarts the interval timer
   assert property (@(posedge clock) disable iff (reset)
      step_fire && result_in.reading_taken |=> state_ff.elapsed_ms == '0)
      else $error("interval timer not cleared by reading");

   // an empty input register never blocks the request side
   assert property (@(posedge clock) disable iff (reset)
      !item_valid_ff |-> req_tready)
      else $error("request side stalled with empty input register");

endmodule

[dv/battery_charge_supervisor_checker.sv]
`timescale 1ns / 1ps

module battery_charge_supervisor_checker
   import bcs_pkg::*;
#(
   parameter int ADC_BITS = ADC_BITS_DEFAULT
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   input  logic        req_tready,
   input  logic [15:0] req_tdata,
   input  logic [1:0]  req_tuser,
   input  logic        rsp_tvalid,
   input  logic        rsp_tready,
   input  logic [23:0] rsp_tdata,
   input  logic        csr_valid,
   input  logic        csr_ready,
   input  logic [1:0]  csr_index,
   input  logic [15:0] csr_data,
   output int          fail_count,
   output int          pending
);

   logic [LEVEL_W-1:0]    start_level;
   logic [LEVEL_W-1:0]    stop_level;
   logic [INTERVAL_W-1:0] read_interval;
   logic [GAIN_W-1:0]     volt_gain;

   logic                  charging;
   logic                  start_pending;
   logic                  low_flag;
   logic                  low_reported;
   logic                  reset_pending;
   logic [ELAPSED_W-1:0]  elapsed_ms;
   logic [LEVEL_W-1:0]    last_level;

   result_type expected_results[$];

   initial begin
      fail_count = 0;
      pending = 0;
   end

   task automatic report_mismatch(input string what, input logic [31:0] want,
                                  input logic [31:0] got);
      if (fail_count < 200)
         $display("%0t mismatch %s: expected %0d got %0d", $realtime, what, want, got);
      fail_count++;
   endtask

   function automatic logic [LEVEL_W-1:0] floor_sub(input logic [LEVEL_W-1:0] a,
                                                    input logic [LEVEL_W-1:0] b);
      return (a > b) ? a - b : '0;
   endfunction

   task automatic act_on_reading(input logic [LEVEL_W-1:0] level, input logic ac);
      if (reset_pending) begin
         charging = 1'b0;
         start_pending = 1'b0;
         low_flag = 1'b0;
         low_reported = 1'b0;
         reset_pending = 1'b0;
      end
      if (!charging) begin
         if (level <= start_level) begin
            start_pending = 1'b1;
            charging = ac;
            // hysteresis only applies when the charger could not be started
            if (!charging) begin
               if (!low_flag && level <= floor_sub(start_level, LOW_SET_MARGIN)) begin
                  low_flag = 1'b1;
                  low_reported = 1'b0;
               end else if (low_flag &&
                            level >= floor_sub(start_level, LOW_CLEAR_MARGIN)) begin
                  low_flag = 1'b0;
                  low_reported = 1'b0;
               end
            end
         end
      end else begin
         low_flag = 1'b0;
         low_reported = 1'b0;
         if (level >= stop_level) begin
            charging = 1'b0;
            start_pending = 1'b0;
         end
      end
   endtask

   task automatic supervisor_step(input item_type it, output result_type res);
      logic [31:0]        due_ms;
      logic [31:0]        product;
      logic [31:0]        scaled;
      logic [LEVEL_W-1:0] level;
      logic               report;
      logic               taken;
      report = 1'b0;
      taken = 1'b0;
      case (it.func)
         FUNC_TICK: begin
            if (elapsed_ms != ELAPSED_MAX)
               elapsed_ms++;
            if (low_flag && !low_reported) begin
               report = 1'b1;
               low_reported = it.report_accepted;
            end
            due_ms = read_interval * MS_PER_UNIT;
            if (!it.in_call && elapsed_ms >= due_ms) begin
               product = (it.adc_sample & ((32'd1 << ADC_BITS) - 1)) * volt_gain;
               scaled = product >> GAIN_SHIFT;
               level = (scaled[31:LEVEL_W] != 0) ? '1 : scaled[LEVEL_W-1:0];
               elapsed_ms = '0;
               last_level = level;
               taken = 1'b1;
               act_on_reading(level, it.ac_present);
            end
         end
         FUNC_AC_GAIN: begin
            if (start_pending && !charging)
               charging = it.ac_present;
         end
         FUNC_AC_LOSS: begin
            if (charging) begin
               charging = 1'b0;
               start_pending = 1'b1;
            end
         end
         FUNC_RESET: begin
            reset_pending = 1'b1;
         end
         default: ;
      endcase
      res.charge_on = charging;
      res.low_battery = low_flag;
      res.report_request = report;
      res.reading_taken = taken;
      res.battery_level = last_level;
   endtask

   always @(posedge clock) begin
      item_type   it;
      result_type got;
      result_type want;
      if (reset) begin
         start_level = START_LEVEL_RESET;
         stop_level = STOP_LEVEL_RESET;
         read_interval = READ_INTERVAL_RESET;
         volt_gain = VOLT_GAIN_RESET;
         charging = 1'b0;
         start_pending = 1'b0;
         low_flag = 1'b0;
         low_reported = 1'b0;
         reset_pending = 1'b0;
         elapsed_ms = '0;
         last_level = '0;
         expected_results.delete();
      end else begin
         if (csr_valid && csr_ready) begin
            case (reg_index_type'(csr_index))
               REG_START_LEVEL:   start_level = csr_data;
               REG_STOP_LEVEL:    stop_level = csr_data;
               REG_READ_INTERVAL: read_interval = csr_data[INTERVAL_W-1:0];
               REG_VOLT_GAIN:     volt_gain = csr_data;
               default: ;
            endcase
         end
         // compare before predicting so a word can never match its own request
         if (rsp_tvalid && rsp_tready) begin
            got.charge_on = rsp_tdata[0];
            got.low_battery = rsp_tdata[1];
            got.report_request = rsp_tdata[2];
            got.reading_taken = rsp_tdata[3];
            got.battery_level = rsp_tdata[4 +: LEVEL_W];
            if (expected_results.size() == 0) begin
               report_mismatch("unexpected response word", 0, rsp_tdata);
            end else begin
               want = expected_results.pop_front();
               if (got.charge_on !== want.charge_on)
                  report_mismatch("charge_on", want.charge_on, got.charge_on);
               if (got.low_battery !== want.low_battery)
                  report_mismatch("low_battery", want.low_battery, got.low_battery);
               if (got.report_request !== want.report_request)
                  report_mismatch("report_request", want.report_request,
                                  got.report_request);
               if (got.reading_taken !== want.reading_taken)
                  report_mismatch("reading_taken", want.reading_taken, got.reading_taken);
               if (got.battery_level !== want.battery_level)
                  report_mismatch("battery_level", want.battery_level, got.battery_level);
            end
         end
         if (req_tvalid && req_tready) begin
            it.func = func_type'(req_tuser);
            it.adc_sample = req_tdata[SAMPLE_W-1:0];
            it.ac_present = req_tdata[10];
            it.in_call = req_tdata[11];
            it.report_accepted = req_tdata[12];
            supervisor_step(it, want);
            expected_results.push_back(want);
         end
      end
      pending = expected_results.size();
   end

endmodule

[dv/battery_charge_supervisor_tb.sv]
`timescale 1ns / 1ps

module battery_charge_supervisor_tb;
   import bcs_pkg::*;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic [15:0] req_tdata = '0;
   logic [1:0]  req_tuser = '0;
   logic        rsp_tready = 1'b1;
   logic        csr_valid = 1'b0;
   logic [1:0]  csr_index = '0;
   logic [15:0] csr_data = '0;
   wire         req_tready;
   wire         rsp_tvalid;
   wire  [23:0] rsp_tdata;
   wire         csr_ready;

   int          fail_count;
   int          pending;

   bit          gaps_on = 1'b0;
   bit          stalls_on = 1'b0;
   int unsigned stall_left = 0;
   int unsigned stall_draw;

   // copy of the programmed settings, used to aim samples at the thresholds
   logic [LEVEL_W-1:0]    cfg_start = START_LEVEL_RESET;
   logic [LEVEL_W-1:0]    cfg_stop = STOP_LEVEL_RESET;
   logic [INTERVAL_W-1:0] cfg_interval = READ_INTERVAL_RESET;
   logic [GAIN_W-1:0]     cfg_gain = VOLT_GAIN_RESET;

   battery_charge_supervisor dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   battery_charge_supervisor_checker charge_check (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data),
      .fail_count (fail_count),
      .pending    (pending)
   );

   always #1 clock = ~clock;

   initial begin
      #5_000_000;
      $display("CHECK FAILED");
      $finish;
   end

   // response backpressure: mostly ready, short stalls, now and then a long one
   always @(negedge clock) begin
      if (!stalls_on) begin
         rsp_tready <= 1'b1;
         stall_left <= 0;
      end else if (stall_left != 0) begin
         stall_left <= stall_left - 1;
      end else begin
         stall_draw = $urandom_range(0, 99);
         if (stall_draw < 60) begin
            rsp_tready <= 1'b1;
            stall_left <= $urandom_range(0, 8);
         end else if (stall_draw < 96) begin
            rsp_tready <= 1'b0;
            stall_left <= $urandom_range(0, 3);
         end else begin
            rsp_tready <= 1'b0;
            stall_left <= $urandom_range(10, 50);
         end
      end
   end

   function automatic int pick_gap();
      int unsigned r;
      r = $urandom_range(0, 99);
      if (r < 55)
         return 0;
      else if (r < 90)
         return $urandom_range(1, 3);
      else if (r < 98)
         return $urandom_range(4, 10);
      return $urandom_range(20, 60);
   endfunction

   task automatic send(input func_type f, input logic [SAMPLE_W-1:0] adc, input logic ac,
                       input logic call, input logic accepted);
      int gap;
      @(negedge clock);
      req_tvalid <= 1'b1;
      req_tuser <= f;
      req_tdata <= {3'b000, accepted, call, ac, adc};
      do @(posedge clock); while (!req_tready);
      gap = gaps_on ? pick_gap() : 0;
      if (gap > 0) begin
         @(negedge clock);
         req_tvalid <= 1'b0;
         repeat (gap - 1) @(negedge clock);
      end
   endtask

   task automatic wait_idle();
      @(negedge clock);
      req_tvalid <= 1'b0;
      while (pending != 0) @(negedge clock);
      repeat (4) @(negedge clock);
   endtask

   task automatic write_reg(input reg_index_type idx, input logic [15:0] value);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= value;
      do @(posedge clock); while (!csr_ready);
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   task automatic configure(input logic [LEVEL_W-1:0] start, input logic [LEVEL_W-1:0] stop,
                            input logic [INTERVAL_W-1:0] interval,
                            input logic [GAIN_W-1:0] gain);
      wait_idle();
      write_reg(REG_START_LEVEL, start);
      write_reg(REG_STOP_LEVEL, stop);
      write_reg(REG_READ_INTERVAL, 16'(interval));
      write_reg(REG_VOLT_GAIN, gain);
      cfg_start = start;
      cfg_stop = stop;
      cfg_interval = interval;
      cfg_gain = gain;
   endtask

   // sample whose scaled level lands close to the given level
   function automatic logic [SAMPLE_W-1:0] sample_for(input int target);
      int v;
      if (cfg_gain == 0)
         return SAMPLE_W'($urandom_range(0, 1023));
      v = (target * (1 << GAIN_SHIFT)) / int'(cfg_gain) + int'($urandom_range(0, 6)) - 3;
      if (v < 0)
         v = 0;
      if (v > 1023)
         v = 1023;
      return v[SAMPLE_W-1:0];
   endfunction

   task automatic send_random();
      int unsigned      r;
      int unsigned      mode;
      int               target;
      func_type         f;
      logic [SAMPLE_W-1:0] adc;
      r = $urandom_range(0, 99);
      if (r < 70)
         f = FUNC_TICK;
      else if (r < 80)
         f = FUNC_AC_GAIN;
      else if (r < 90)
         f = FUNC_AC_LOSS;
      else
         f = FUNC_RESET;
      mode = $urandom_range(0, 9);
      if (mode < 4) begin
         target = int'(cfg_start) - int'($urandom_range(0, 25));
         adc = sample_for(target < 0 ? 0 : target);
      end else if (mode < 6) begin
         adc = sample_for(int'(cfg_start) + int'($urandom_range(0, 6)));
      end else if (mode < 8) begin
         adc = sample_for(int'(cfg_stop) + int'($urandom_range(0, 6)) - 3);
      end else if (mode == 8) begin
         adc = $urandom_range(0, 1) ? '1 : '0;
      end else begin
         adc = SAMPLE_W'($urandom_range(0, 1023));
      end
      send(f, adc, $urandom_range(0, 99) < 65, $urandom_range(0, 99) < 10,
           $urandom_range(0, 1) != 0);
   endtask

   initial begin
      logic [GAIN_W-1:0]  gain;
      logic [LEVEL_W-1:0] start;
      logic [LEVEL_W-1:0] stop;
      logic [INTERVAL_W-1:0] interval;
      int unsigned        r;
      int                 top_level;
      int                 span;

      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // reset settings: interval too long for any reading here
      send(FUNC_TICK, 10'd1023, 1'b1, 1'b0, 1'b1);
      send(FUNC_AC_GAIN, 10'd0, 1'b1, 1'b0, 1'b0);
      send(FUNC_AC_LOSS, 10'd0, 1'b0, 1'b0, 1'b0);
      send(FUNC_RESET, 10'd0, 1'b0, 1'b0, 1'b0);

      // unity gain: level equals the sample
      configure(16'd400, 16'd600, 10'd0, 16'd1024);
      send(FUNC_TICK, 10'd0, 1'b0, 1'b0, 1'b0);     // low flag set, start held
      send(FUNC_TICK, 10'd0, 1'b0, 1'b0, 1'b0);     // report not taken
      send(FUNC_TICK, 10'd0, 1'b0, 1'b0, 1'b1);     // report delivered
      send(FUNC_TICK, 10'd0, 1'b0, 1'b0, 1'b1);
      send(FUNC_AC_GAIN, 10'd0, 1'b1, 1'b0, 1'b0);  // held start goes ahead
      send(FUNC_AC_LOSS, 10'd0, 1'b0, 1'b0, 1'b0);
      send(FUNC_AC_GAIN, 10'd0, 1'b0, 1'b0, 1'b0);
      send(FUNC_AC_GAIN, 10'd0, 1'b1, 1'b0, 1'b0);
      send(FUNC_TICK, 10'd1023, 1'b1, 1'b0, 1'b0);  // above stop level
      send(FUNC_TICK, 10'd395, 1'b0, 1'b1, 1'b0);   // call suppresses reading
      send(FUNC_TICK, 10'd395, 1'b0, 1'b0, 1'b0);
      send(FUNC_TICK, 10'd385, 1'b0, 1'b0, 1'b0);   // set threshold
      send(FUNC_TICK, 10'd396, 1'b0, 1'b0, 1'b0);   // clear threshold
      send(FUNC_RESET, 10'd0, 1'b0, 1'b0, 1'b0);
      send(FUNC_TICK, 10'd200, 1'b1, 1'b0, 1'b0);   // pending reset applied first
      send(FUNC_TICK, 10'd600, 1'b1, 1'b0, 1'b0);
      send(FUNC_TICK, 10'd601, 1'b0, 1'b0, 1'b0);

      // start level below the set margin: the set threshold clamps at zero
      configure(16'd10, 16'd20, 10'd0, 16'd1024);
      send(FUNC_TICK, 10'd0, 1'b0, 1'b0, 1'b0);
      send(FUNC_TICK, 10'd4, 1'b0, 1'b0, 1'b0);
      send(FUNC_TICK, 10'd5, 1'b0, 1'b0, 1'b1);

      for (int phase = 0; phase < 8; phase++) begin
         if (phase == 0) begin
            gain = '1;
            start = '1;
            stop = '1;
            interval = 10'd0;
         end else if (phase == 1) begin
            gain = '0;
            start = '0;
            stop = '0;
            interval = 10'd1;
         end else begin
            r = $urandom_range(0, 99);
            if (r < 40)
               gain = 16'd1024;
            else if (r < 60)
               gain = GAIN_W'($urandom_range(512, 4096));
            else if (r < 70)
               gain = '0;
            else if (r < 80)
               gain = '1;
            else
               gain = GAIN_W'($urandom_range(0, 65535));
            top_level = (1023 * int'(gain)) >> GAIN_SHIFT;
            start = LEVEL_W'($urandom_range(0, top_level));
            span = int'($urandom_range(0, 400));
            stop = (int'(start) + span > top_level) ? LEVEL_W'(top_level)
                   : LEVEL_W'(int'(start) + span);
            r = $urandom_range(0, 99);
            interval = (r < 60) ? 10'd0 : (r < 90) ? 10'd1
                       : INTERVAL_W'($urandom_range(2, 1023));
         end
         configure(start, stop, interval, gain);
         gaps_on = $urandom_range(0, 99) < 80;
         stalls_on <= $urandom_range(0, 99) < 80;
         repeat (130) send_random();
      end

      // short interval with full gain; a call holds off the reading well past
      // the due time
      configure(LEVEL_W'($urandom_range(0, 65535)), LEVEL_W'($urandom_range(0, 65535)),
                10'd1, '1);
      gaps_on = 1'b0;
      stalls_on <= 1'b0;
      repeat (110)
         send(FUNC_TICK, SAMPLE_W'($urandom_range(0, 1023)), $urandom_range(0, 1) != 0,
              1'b1, $urandom_range(0, 1) != 0);
      send(FUNC_TICK, SAMPLE_W'($urandom_range(0, 1023)), $urandom_range(0, 1) != 0,
           1'b0, $urandom_range(0, 1) != 0);
      gaps_on = 1'b1;
      stalls_on <= 1'b1;
      repeat (50) send_random();

      @(negedge clock);
      req_tvalid <= 1'b0;
      while (pending != 0) @(negedge clock);
      repeat (10) @(negedge clock);
      if (fail_count == 0 && pending == 0)
         $display("CHECK OK");
      else
         $display("CHECK FAILED");
      $finish;
   end

endmodule
